// ===== rtl/kcl_pkg.sv =====
// kcl_pkg: shared types and constants of the keypad code lock
// key codes, event codes, service codes, configuration indexes, payload structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package kcl_pkg;

	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 2;
	localparam int MAX_CODE_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_CODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WARN_ERRORS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOCK_ERRORS  = 2'd2;

	localparam logic [19:0] DEFAULT_CODE_RESET = 20'h12345;
	localparam logic [3:0]  WARN_ERRORS_RESET  = 4'd2;
	localparam logic [3:0]  LOCK_ERRORS_RESET  = 4'd4;
	localparam logic [19:0] STORED_CODE_RESET  = 20'h22222;

	localparam logic [3:0] KEY_STAR = 4'd10;
	localparam logic [3:0] KEY_HASH = 4'd11;
	localparam logic [3:0] ERR_MAX  = 4'd15;

	localparam logic [MAX_CODE_W-1:0] SVC_CHANGE = 32'h000A001B;
	localparam logic [MAX_CODE_W-1:0] SVC_RESET  = 32'h000A002B;
	localparam logic [MAX_CODE_W-1:0] SVC_HARD   = 32'h000A003B;
	localparam logic [MAX_CODE_W-1:0] SVC_ADD    = 32'h000A101B;
	localparam logic [MAX_CODE_W-1:0] SVC_DEL    = 32'h000A102B;
	localparam logic [MAX_CODE_W-1:0] SVC_DELALL = 32'h000A103B;

	localparam logic [4:0] EV_KEY        = 5'd0;
	localparam logic [4:0] EV_OPEN       = 5'd1;
	localparam logic [4:0] EV_WRONG      = 5'd2;
	localparam logic [4:0] EV_WAIT       = 5'd3;
	localparam logic [4:0] EV_LOCKOUT    = 5'd4;
	localparam logic [4:0] EV_HARD       = 5'd5;
	localparam logic [4:0] EV_ENTER_NEW  = 5'd6;
	localparam logic [4:0] EV_FIRST      = 5'd7;
	localparam logic [4:0] EV_CHANGED    = 5'd8;
	localparam logic [4:0] EV_MISMATCH   = 5'd9;
	localparam logic [4:0] EV_OLD_OK     = 5'd10;
	localparam logic [4:0] EV_OLD_BAD    = 5'd11;
	localparam logic [4:0] EV_RESET_DONE = 5'd12;
	localparam logic [4:0] EV_CANCEL     = 5'd13;
	localparam logic [4:0] EV_ADD_TAG    = 5'd14;
	localparam logic [4:0] EV_DEL_TAG    = 5'd15;
	localparam logic [4:0] EV_DEL_ALL    = 5'd16;
	localparam logic [4:0] EV_IGNORED    = 5'd17;
	localparam logic [4:0] EV_TOGGLE     = 5'd18;

	typedef struct packed {
		logic [3:0] key_code;
	} key_t;

	typedef struct packed {
		logic [4:0] event_res;
		logic [2:0] entered_count;
		logic [3:0] error_total;
		logic       is_locked;
	} result_t;

	typedef struct packed {
		logic [19:0] default_code;
		logic [3:0]  warn_errors;
		logic [3:0]  lock_errors;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/kcl_stream_if.sv =====
// kcl_stream_if: valid/ready channel carrying one payload per transaction
// payload type is a parameter, normally a struct from kcl_pkg
`timescale 1ns / 1ps
`default_nettype none
interface kcl_stream_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/kcl_cfg_regs.sv =====
// kcl_cfg_regs: configuration registers of the keypad code lock
// depends on kcl_pkg
`timescale 1ns / 1ps
`default_nettype none
module kcl_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kcl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [kcl_pkg::CFG_DATA_W-1:0]  cfg_data,
	output kcl_pkg::cfg_t                       cfg
);
	kcl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_code <= kcl_pkg::DEFAULT_CODE_RESET;
			cfg_q.warn_errors  <= kcl_pkg::WARN_ERRORS_RESET;
			cfg_q.lock_errors  <= kcl_pkg::LOCK_ERRORS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kcl_pkg::CFG_DEFAULT_CODE: cfg_q.default_code <= cfg_data;
				kcl_pkg::CFG_WARN_ERRORS:  cfg_q.warn_errors  <= cfg_data[3:0];
				kcl_pkg::CFG_LOCK_ERRORS:  cfg_q.lock_errors  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// ===== rtl/kcl_in_reg.sv =====
// kcl_in_reg: input register stage for key transactions
// depends on kcl_pkg and kcl_stream_if
`timescale 1ns / 1ps
`default_nettype none
module kcl_in_reg (
	input  wire logic   clk,
	input  wire logic   arst_n,
	kcl_stream_if.sink   up,
	kcl_stream_if.source down
);
	logic          valid_s1;
	kcl_pkg::key_t key_s1;
	logic          take;

	assign up.ready = !valid_s1 || down.ready;
	assign take     = up.valid && up.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up.ready) begin
			valid_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_s1 <= up.data;
		end
	end

	assign down.valid = valid_s1;
	assign down.data  = key_s1;
endmodule
`default_nettype wire

// ===== rtl/kcl_judge.sv =====
// kcl_judge: lock state, code evaluation and result register
// depends on kcl_pkg and kcl_stream_if
`timescale 1ns / 1ps
`default_nettype none
module kcl_judge #(
	parameter int CODE_LENGTH = 5
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  kcl_pkg::cfg_t cfg,
	kcl_stream_if.sink    keys,
	kcl_stream_if.source  results
);
	localparam int CW    = 4 * CODE_LENGTH;
	localparam int CNT_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LENGTH - 1);

	localparam logic [2:0] PH_NORMAL     = 3'd0;
	localparam logic [2:0] PH_LOCKED     = 3'd1;
	localparam logic [2:0] PH_NEW_FIRST  = 3'd2;
	localparam logic [2:0] PH_NEW_SECOND = 3'd3;
	localparam logic [2:0] PH_OLD_CHECK  = 3'd4;
	localparam logic [2:0] PH_CHOOSE     = 3'd5;

	logic [CW-1:0]    entry_q, entry_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CW-1:0]    stored_q, stored_d;
	logic [CW-1:0]    first_q, first_d;
	logic [3:0]       err_q, err_d;
	logic [2:0]       phase_q, phase_d;
	logic             choice_q, choice_d;
	logic [4:0]       ev;

	logic             valid_s2;
	kcl_pkg::result_t result_s2;
	logic             fire;

	logic [3:0]       key;
	logic [CW+3:0]    shifted;
	logic [CW-1:0]    code;
	logic [CW-1:0]    dflt;

	assign keys.ready = !valid_s2 || results.ready;
	assign fire       = keys.valid && keys.ready;

	assign key     = keys.data.key_code;
	assign shifted = {entry_q, key};
	assign code    = shifted[CW-1:0];
	assign dflt    = CW'(cfg.default_code);

	always_comb begin
		entry_d  = entry_q;
		count_d  = count_q;
		stored_d = stored_q;
		first_d  = first_q;
		err_d    = err_q;
		phase_d  = phase_q;
		choice_d = choice_q;
		ev       = kcl_pkg::EV_IGNORED;
		if (key <= kcl_pkg::KEY_HASH) begin
			if (phase_q == PH_CHOOSE) begin
				if (key == kcl_pkg::KEY_STAR) begin
					choice_d = !choice_q;
					ev       = kcl_pkg::EV_TOGGLE;
				end else if (key == kcl_pkg::KEY_HASH) begin
					if (!choice_q) begin
						stored_d = dflt;
						ev       = kcl_pkg::EV_RESET_DONE;
					end else begin
						ev = kcl_pkg::EV_CANCEL;
					end
					phase_d  = PH_NORMAL;
					choice_d = 1'b0;
				end
			end else if (count_q != CNT_LAST) begin
				entry_d = code;
				count_d = count_q + 1'b1;
				ev      = kcl_pkg::EV_KEY;
			end else begin
				entry_d = '0;
				count_d = '0;
				case (phase_q)
					PH_LOCKED: begin
						if (code == CW'(kcl_pkg::SVC_HARD)) begin
							stored_d = dflt;
							phase_d  = PH_NORMAL;
							ev       = kcl_pkg::EV_HARD;
						end
					end
					PH_NEW_FIRST: begin
						first_d = code;
						phase_d = PH_NEW_SECOND;
						ev      = kcl_pkg::EV_FIRST;
					end
					PH_NEW_SECOND: begin
						phase_d = PH_NORMAL;
						if (code == first_q) begin
							stored_d = code;
							ev       = kcl_pkg::EV_CHANGED;
						end else begin
							ev = kcl_pkg::EV_MISMATCH;
						end
					end
					PH_OLD_CHECK: begin
						if (code == stored_q) begin
							phase_d  = PH_CHOOSE;
							choice_d = 1'b0;
							ev       = kcl_pkg::EV_OLD_OK;
						end else begin
							phase_d = PH_NORMAL;
							ev      = kcl_pkg::EV_OLD_BAD;
						end
					end
					default: begin
						if (code == CW'(kcl_pkg::SVC_CHANGE)) begin
							phase_d = PH_NEW_FIRST;
							ev      = kcl_pkg::EV_ENTER_NEW;
						end else if (code == CW'(kcl_pkg::SVC_RESET)) begin
							phase_d = PH_OLD_CHECK;
							ev      = kcl_pkg::EV_KEY;
						end else if (code == CW'(kcl_pkg::SVC_ADD)) begin
							ev = kcl_pkg::EV_ADD_TAG;
						end else if (code == CW'(kcl_pkg::SVC_DEL)) begin
							ev = kcl_pkg::EV_DEL_TAG;
						end else if (code == CW'(kcl_pkg::SVC_DELALL)) begin
							ev = kcl_pkg::EV_DEL_ALL;
						end else if (code == stored_q) begin
							ev = kcl_pkg::EV_OPEN;
						end else if (code == CW'(kcl_pkg::SVC_HARD)) begin
							stored_d = dflt;
							ev       = kcl_pkg::EV_HARD;
						end else begin
							ev = kcl_pkg::EV_WRONG;
							if (err_q == cfg.warn_errors) begin
								ev = kcl_pkg::EV_WAIT;
							end
							if (err_q == cfg.lock_errors) begin
								ev      = kcl_pkg::EV_LOCKOUT;
								phase_d = PH_LOCKED;
							end
							if (err_q != kcl_pkg::ERR_MAX) begin
								err_d = err_q + 4'd1;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			count_q  <= '0;
			stored_q <= CW'(kcl_pkg::STORED_CODE_RESET);
			err_q    <= '0;
			phase_q  <= PH_NORMAL;
			choice_q <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				entry_q  <= entry_d;
				count_q  <= count_d;
				stored_q <= stored_d;
				err_q    <= err_d;
				phase_q  <= phase_d;
				choice_q <= choice_d;
			end
			if (keys.ready) begin
				valid_s2 <= keys.valid;
			end
		end
	end

	// first code of a change is written before it is ever compared
	always_ff @(posedge clk) begin
		if (fire) begin
			first_q                 <= first_d;
			result_s2.event_res     <= ev;
			result_s2.entered_count <= 3'(count_d);
			result_s2.error_total   <= err_d;
			result_s2.is_locked     <= (phase_d == PH_LOCKED);
		end
	end

	assign results.valid = valid_s2;
	assign results.data  = result_s2;
endmodule
`default_nettype wire

// ===== rtl/keypad_code_lock.sv =====
// Keypad code lock: gathers CODE_LENGTH keys into a code and judges it against the service
// codes, the stored password and the hard-reset code, with error counting, penalty wait,
// lockout, change-password and reset-password flows. One key transaction is taken in every
// clock cycle while the results are not stalled, and each key passes through an input
// register, then one combinational judge stage that updates the lock state and loads the
// result register. A stalled result register holds the input register, so at most two
// keys are in flight. Configuration registers take effect for the next key judged and
// should be written only while no key is in flight. Depends on kcl_pkg, kcl_stream_if,
// kcl_cfg_regs, kcl_in_reg and kcl_judge.
`timescale 1ns / 1ps
`default_nettype none
module keypad_code_lock #(
	parameter int CODE_LENGTH = 5
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [kcl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [kcl_pkg::CFG_DATA_W-1:0]  cfg_data,
	kcl_stream_if.sink                           keys,
	kcl_stream_if.source                         results
);
	kcl_pkg::cfg_t cfg;

	kcl_stream_if #(.data_t(kcl_pkg::key_t)) staged ();

	kcl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kcl_in_reg u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (keys),
		.down   (staged)
	);

	kcl_judge #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_judge (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.keys    (staged),
		.results (results)
	);
endmodule
`default_nettype wire
